// ===== rtl/core/ppmfig_pkg.sv =====
// ppmfig_pkg: shared types and constants for the PPM frame interval generator.
// Holds field widths, segment and register codes, phase codes and timing constants.
// No dependencies.
package ppmfig_pkg;

  // Field widths
  localparam int ACTION_W   = 1;
  localparam int INDEX_W    = 4;
  localparam int VALUE_W    = 16;
  localparam int CENTER_W   = 12;
  localparam int INTERVAL_W = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Internal widths
  localparam int PHASE_W = 7;   // signed frame position
  localparam int REM_W   = 20;  // signed frame remainder, covers a full wrap-free frame
  localparam int SYNC_W  = 11;  // latched sync width, 200..1600
  localparam int CALC_W  = 16;  // signed channel pulse arithmetic

  localparam int MAX_CHANNELS_DEF = 16;

  // Timing constants, half-microsecond counts unless noted
  localparam int SETUP_COUNTS = 1000;
  localparam int GAP_MIN      = 9000;
  localparam int GAP_MAX      = 65535;
  localparam int CLAMP_STD    = 1024;
  localparam int CLAMP_EXT    = 1280;
  localparam int SYNC_BASE    = 600;   // 2 * 300 us
  localparam int SYNC_STEP    = 100;   // 2 * 50 us
  localparam int FRAME_BASE   = 44;    // 22.5 ms frame minus the setup segment, in 0.5 ms
  localparam int FRAME_UNIT   = 1000;  // 0.5 ms in counts
  localparam int CENTER_RESET = 1500;

  // Config step limits
  localparam int SYNC_STEP_LO  = -4;
  localparam int SYNC_STEP_HI  = 10;
  localparam int FRAME_STEP_LO = -20;
  localparam int FRAME_STEP_HI = 35;
  localparam int COUNT_STEP_LO = -2;
  localparam int COUNT_STEP_HI = 4;
  localparam int COUNT_BASE    = 8;

  // Special frame positions; even positions are sync, odd are channel pulses
  localparam logic signed [PHASE_W-1:0] PHASE_SETUP = -7'sd1;
  localparam logic signed [PHASE_W-1:0] PHASE_GAP   = -7'sd2;

  typedef enum logic [KIND_W-1:0] {
    SEG_SETUP   = 2'd0,
    SEG_SYNC    = 2'd1,
    SEG_CHANNEL = 2'd2,
    SEG_GAP     = 2'd3
  } seg_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLARITY    = 3'd0,
    REG_EXTENDED    = 3'd1,
    REG_SYNC_STEP   = 3'd2,
    REG_FRAME_STEP  = 3'd3,
    REG_COUNT_STEP  = 3'd4
  } cfg_reg_t;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

endpackage

// ===== rtl/core/ppm_frame_interval_generator_top.sv =====
// ppm_frame_interval_generator_top: RC PPM frame interval generator, single module.
// Depends on ppmfig_pkg for widths, segment codes and timing constants.
//
// Usage:
//   The input channel carries one beat per item. A beat with action = 1 writes
//   value and center into the channel table and yields no result. A beat with
//   action = 0 is a timer compare tick and yields exactly one result beat: the
//   length of the next output segment in half-microsecond counts, its kind,
//   the channel carried (zero unless a channel pulse) and the latched idle level.
//   Frame order: setup (1000), then sync/channel pairs, a final sync, then a gap
//   that pads the frame to its set length (min 9000, saturated at 65535).
//   The config channel writes registers 0..4 by index; it is always ready and should
//   be written only while the block is idle. All but the count step latch at setup.
// Latency and throughput:
//   A tick's result is valid in the cycle after it is taken. One beat is accepted
//   per cycle unless a result is held by a stalled receiver; a pulse's table read,
//   clamp and two adds, or the gap limit, sit between state and result register.
// Reset and stall:
//   Synchronous reset returns to the setup position, clears config and restores
//   the table (values 0, centers 1500 us). While the receiver stalls, the result
//   register holds and in_ready drops only if a result is waiting in it.
module ppm_frame_interval_generator_top #(
  parameter int MAX_CHANNELS = ppmfig_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppmfig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppmfig_pkg::CFG_DATA_W-1:0]     cfg_data,
  // item input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ppmfig_pkg::ACTION_W-1:0]       action,
  input  logic [ppmfig_pkg::INDEX_W-1:0]        channel_index,
  input  logic signed [ppmfig_pkg::VALUE_W-1:0] channel_value,
  input  logic [ppmfig_pkg::CENTER_W-1:0]       channel_center,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ppmfig_pkg::INTERVAL_W-1:0]     interval_counts,
  output logic [ppmfig_pkg::KIND_W-1:0]         segment_kind,
  output logic [ppmfig_pkg::INDEX_W-1:0]        pulse_channel,
  output logic                                  idle_level
);
  import ppmfig_pkg::*;

  localparam int CH_IDX_W = $clog2(MAX_CHANNELS);
  localparam logic [INDEX_W:0] MAX_N = (INDEX_W+1)'(MAX_CHANNELS);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic              cfg_polarity;
  logic              cfg_extended;
  logic signed [4:0] cfg_sync_step;
  logic signed [6:0] cfg_frame_step;
  logic signed [3:0] cfg_count_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_polarity   <= 1'b0;
      cfg_extended   <= 1'b0;
      cfg_sync_step  <= '0;
      cfg_frame_step <= '0;
      cfg_count_step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLARITY:   cfg_polarity   <= cfg_data[0];
        REG_EXTENDED:   cfg_extended   <= cfg_data[0];
        REG_SYNC_STEP:  cfg_sync_step  <= cfg_data[4:0];
        REG_FRAME_STEP: cfg_frame_step <= cfg_data[6:0];
        REG_COUNT_STEP: cfg_count_step <= cfg_data[3:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state and channel table
  // ---------------------------------------------------------------------------
  logic signed [PHASE_W-1:0] phase, phase_next;
  logic signed [REM_W-1:0]   frame_remaining, frame_remaining_next;
  logic                      clamp_ext, clamp_ext_next;
  logic [SYNC_W-1:0]         sync_width, sync_width_next;
  logic                      idle_latched, idle_latched_next;

  logic [VALUE_W-1:0]  ch_value  [MAX_CHANNELS];
  logic [CENTER_W-1:0] ch_center [MAX_CHANNELS];

  logic in_fire, tick_fire, write_fire;
  assign in_ready   = out_ready || !out_valid;
  assign in_fire    = in_valid && in_ready;
  assign tick_fire  = in_fire && (action == ACT_TICK);
  assign write_fire = in_fire && (action == ACT_WRITE);

  // Saturated config steps
  logic signed [4:0]         ss_sat;
  logic signed [6:0]         fs_sat;
  logic signed [3:0]         cs_sat;
  logic signed [11:0]        sync_calc;
  logic [7:0]                frame_mult;
  logic [INDEX_W:0]          n_raw, n_cap;
  logic signed [PHASE_W-1:0] phase_end, phase_inc;

  always_comb begin
    ss_sat = cfg_sync_step;
    if (cfg_sync_step < 5'(SYNC_STEP_LO)) ss_sat = 5'(SYNC_STEP_LO);
    else if (cfg_sync_step > 5'(SYNC_STEP_HI)) ss_sat = 5'(SYNC_STEP_HI);

    fs_sat = cfg_frame_step;
    if (cfg_frame_step < 7'(FRAME_STEP_LO)) fs_sat = 7'(FRAME_STEP_LO);
    else if (cfg_frame_step > 7'(FRAME_STEP_HI)) fs_sat = 7'(FRAME_STEP_HI);

    cs_sat = cfg_count_step;
    if (cfg_count_step < 4'(COUNT_STEP_LO)) cs_sat = 4'(COUNT_STEP_LO);
    else if (cfg_count_step > 4'(COUNT_STEP_HI)) cs_sat = 4'(COUNT_STEP_HI);

    sync_calc  = 12'(ss_sat) * 12'(SYNC_STEP) + 12'(SYNC_BASE);
    frame_mult = 8'($signed({fs_sat[6], fs_sat}) + 8'(FRAME_BASE));

    // channel count 4..16, capped by the table depth
    n_raw = (INDEX_W+1)'($signed({{2{cs_sat[3]}}, cs_sat}) * 6'sd2 + 6'(COUNT_BASE));
    n_cap = (n_raw > MAX_N) ? MAX_N : n_raw;
    phase_end = $signed({1'b0, n_cap, 1'b0});
    phase_inc = phase + 7'sd1;
  end

  // Channel pulse: 2*center + clamped value - sync, floored at zero
  logic [CH_IDX_W-1:0]      chan_sel;
  logic signed [CALC_W-1:0] value_s, range_s, value_clamped, pulse_raw;
  logic [INTERVAL_W-1:0]    pulse_counts;

  always_comb begin
    chan_sel = phase[CH_IDX_W:1];
    value_s  = $signed(ch_value[chan_sel]);
    range_s  = clamp_ext ? CALC_W'(CLAMP_EXT) : CALC_W'(CLAMP_STD);
    value_clamped = value_s;
    if (value_s > range_s) value_clamped = range_s;
    else if (value_s < -range_s) value_clamped = -range_s;
    pulse_raw = $signed({3'b000, ch_center[chan_sel], 1'b0}) + value_clamped
              - $signed({{(CALC_W-SYNC_W){1'b0}}, sync_width});
    pulse_counts = pulse_raw[CALC_W-1] ? '0 : INTERVAL_W'(pulse_raw);
  end

  // Gap: remainder padded to the minimum, saturated on overflow or wrap
  logic [INTERVAL_W-1:0] gap_counts;
  always_comb begin
    if (frame_remaining < 0 || frame_remaining > REM_W'(GAP_MAX))
      gap_counts = INTERVAL_W'(GAP_MAX);
    else if (frame_remaining > REM_W'(GAP_MIN))
      gap_counts = INTERVAL_W'(frame_remaining);
    else
      gap_counts = INTERVAL_W'(GAP_MIN);
  end

  // Next frame state and the result for a tick
  seg_kind_t             kind_next;
  logic [INTERVAL_W-1:0] counts_next;
  logic [INDEX_W-1:0]    chan_next;

  always_comb begin
    phase_next           = phase;
    frame_remaining_next = frame_remaining;
    clamp_ext_next       = clamp_ext;
    sync_width_next      = sync_width;
    idle_latched_next    = idle_latched;
    kind_next            = SEG_SETUP;
    counts_next          = INTERVAL_W'(SETUP_COUNTS);
    chan_next            = '0;
    if (phase == PHASE_GAP) begin
      kind_next   = SEG_GAP;
      counts_next = gap_counts;
      phase_next  = PHASE_SETUP;
    end else if (phase < 0) begin
      clamp_ext_next       = cfg_extended;
      sync_width_next      = SYNC_W'(sync_calc);
      frame_remaining_next = REM_W'(frame_mult) * REM_W'(FRAME_UNIT);
      idle_latched_next    = cfg_polarity;
      phase_next           = '0;
    end else if (!phase[0]) begin
      kind_next            = SEG_SYNC;
      counts_next          = INTERVAL_W'(sync_width);
      frame_remaining_next = frame_remaining - $signed({{(REM_W-SYNC_W){1'b0}}, sync_width});
      // count is read live, so a shrink mid frame closes at this sync
      phase_next           = (phase_inc > phase_end) ? PHASE_GAP : phase_inc;
    end else begin
      kind_next            = SEG_CHANNEL;
      counts_next          = pulse_counts;
      chan_next            = INDEX_W'(chan_sel);
      frame_remaining_next = frame_remaining
                           - $signed({{(REM_W-INTERVAL_W){1'b0}}, pulse_counts});
      phase_next           = phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PHASE_SETUP;
      frame_remaining <= '0;
      clamp_ext       <= 1'b0;
      sync_width      <= '0;
      idle_latched    <= 1'b0;
    end else if (tick_fire) begin
      phase           <= phase_next;
      frame_remaining <= frame_remaining_next;
      clamp_ext       <= clamp_ext_next;
      sync_width      <= sync_width_next;
      idle_latched    <= idle_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        ch_value[i]  <= '0;
        ch_center[i] <= CENTER_W'(CENTER_RESET);
      end
    end else if (write_fire && ({1'b0, channel_index} < MAX_N)) begin
      ch_value[channel_index[CH_IDX_W-1:0]]  <= channel_value;
      ch_center[channel_index[CH_IDX_W-1:0]] <= channel_center;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      interval_counts <= counts_next;
      segment_kind    <= kind_next;
      pulse_channel   <= chan_next;
      idle_level      <= idle_latched_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_setup_starts_frame: assert property (@(posedge clk) disable iff (rst)
    tick_fire && phase == PHASE_SETUP |=> phase == '0)
    else $error("setup tick did not start the frame");

  a_phase_bounded: assert property (@(posedge clk) disable iff (rst)
    phase < 0 || phase <= $signed(PHASE_W'(2 * MAX_CHANNELS)))
    else $error("frame position ran past the channel table");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    write_fire |=> !out_valid)
    else $error("table write produced a result");

  a_gap_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_kind == SEG_GAP |-> interval_counts >= INTERVAL_W'(GAP_MIN))
    else $error("frame gap below minimum");

  a_chan_only_on_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_kind != SEG_CHANNEL |-> pulse_channel == '0)
    else $error("channel number on a non-pulse segment");

endmodule

// ===== tb/tb_ppm_frame_interval_generator_top.sv =====
// Self-checking testbench for ppm_frame_interval_generator_top: scoreboard class with
// an in-house model of the frame sequencer, plus drivers for the three channels.
// Depends on ppmfig_pkg and the top-level RTL only.

class interval_scoreboard;

  typedef struct {
    logic [15:0]            counts;
    ppmfig_pkg::seg_kind_t  kind;
    logic [3:0]             chan;
    logic                   idle;
  } segment_t;

  localparam int MAX_CH = 16;

  // raw register bits, sign and range handled at setup, the count step at each sync
  bit        pol, ext;
  bit [4:0]  sync_raw;
  bit [6:0]  frame_raw;
  bit [3:0]  count_raw;

  // frame sequencer state
  int        phase;
  bit [31:0] remaining;
  int        clamp, sync_len;
  bit        idle;
  bit [15:0] values[MAX_CH];
  bit [11:0] centers[MAX_CH];

  segment_t    expected_segments[$];
  int unsigned fails, ticks, table_writes, reg_writes;
  int unsigned by_kind[4];

  function new();
    phase = ppmfig_pkg::PHASE_SETUP;
    for (int i = 0; i < MAX_CH; i++) begin
      values[i]  = '0;
      centers[i] = 12'd1500;
    end
  endfunction

  function int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function void write_reg(logic [2:0] idx, logic [6:0] data);
    reg_writes++;
    case (idx)
      ppmfig_pkg::REG_POLARITY:   pol       = data[0];
      ppmfig_pkg::REG_EXTENDED:   ext       = data[0];
      ppmfig_pkg::REG_SYNC_STEP:  sync_raw  = data[4:0];
      ppmfig_pkg::REG_FRAME_STEP: frame_raw = data[6:0];
      ppmfig_pkg::REG_COUNT_STEP: count_raw = data[3:0];
      default: ;
    endcase
  endfunction

  // Accepted input beat: table writes update state, ticks produce one segment.
  function void take_beat(logic act, logic [3:0] idx, logic [15:0] val, logic [11:0] ctr);
    segment_t seg;
    int ss, fs, cs, n, d;
    if (act == ppmfig_pkg::ACT_WRITE) begin
      values[idx]  = val;
      centers[idx] = ctr;
      table_writes++;
      return;
    end
    ticks++;
    seg.chan = '0;
    if (phase == ppmfig_pkg::PHASE_GAP) begin
      if (remaining > 32'd65535)     seg.counts = 16'hFFFF;
      else if (remaining > 32'd9000) seg.counts = remaining[15:0];
      else                           seg.counts = 16'd9000;
      seg.kind = ppmfig_pkg::SEG_GAP;
      phase = ppmfig_pkg::PHASE_SETUP;
    end else if (phase < 0) begin
      ss = clip(int'($signed(sync_raw)), ppmfig_pkg::SYNC_STEP_LO, ppmfig_pkg::SYNC_STEP_HI);
      fs = clip(int'($signed(frame_raw)), ppmfig_pkg::FRAME_STEP_LO,
                ppmfig_pkg::FRAME_STEP_HI);
      clamp     = ext ? 1280 : 1024;
      sync_len  = (300 + 50 * ss) * 2;
      remaining = 32'((45 + fs) * 1000 - 1000);
      idle      = pol;
      phase     = 0;
      seg.counts = 16'd1000;
      seg.kind   = ppmfig_pkg::SEG_SETUP;
    end else if ((phase % 2) == 0) begin
      // channel count is read live here, so a cut mid frame ends it at this sync
      cs = clip(int'($signed(count_raw)), ppmfig_pkg::COUNT_STEP_LO,
                ppmfig_pkg::COUNT_STEP_HI);
      n = 8 + 2 * cs;
      if (n > MAX_CH) n = MAX_CH;
      remaining -= 32'(sync_len);
      phase++;
      if (phase > 2 * n) phase = ppmfig_pkg::PHASE_GAP;
      seg.counts = 16'(sync_len);
      seg.kind   = ppmfig_pkg::SEG_SYNC;
    end else begin
      seg.chan = 4'(phase >> 1);
      d = 2 * int'(centers[seg.chan])
          + clip(int'($signed(values[seg.chan])), -clamp, clamp) - sync_len;
      if (d < 0) d = 0;
      remaining -= 32'(d);
      phase++;
      seg.counts = 16'(d);
      seg.kind   = ppmfig_pkg::SEG_CHANNEL;
    end
    seg.idle = idle;
    expected_segments.push_back(seg);
  endfunction

  function void check_segment(logic [15:0] counts, logic [1:0] kind, logic [3:0] chan,
                              logic lvl);
    segment_t exp_seg;
    if (expected_segments.size() == 0) begin
      fails++;
      $display("%0t: unexpected result beat: counts %0d kind %0d channel %0d", $time,
               counts, kind, chan);
      return;
    end
    exp_seg = expected_segments.pop_front();
    by_kind[exp_seg.kind]++;
    if (counts !== exp_seg.counts) begin
      fails++;
      $display("%0t: interval_counts expected %0d actual %0d", $time, exp_seg.counts, counts);
    end
    if (kind !== exp_seg.kind) begin
      fails++;
      $display("%0t: segment_kind expected %0d actual %0d", $time, exp_seg.kind, kind);
    end
    if (chan !== exp_seg.chan) begin
      fails++;
      $display("%0t: pulse_channel expected %0d actual %0d", $time, exp_seg.chan, chan);
    end
    if (lvl !== exp_seg.idle) begin
      fails++;
      $display("%0t: idle_level expected %0d actual %0d", $time, exp_seg.idle, lvl);
    end
  endfunction

  function int pending();
    return expected_segments.size();
  endfunction

endclass

module tb_ppm_frame_interval_generator_top;
  import ppmfig_pkg::*;

  // generous for ~700 beats, even with the worst stalls and idle bursts
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          NUM_SETTINGS = 8;
  localparam int          ITEMS_PER_SETTING = 85;

  logic clk = 1'b0;
  logic rst;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic                      in_valid;
  logic                      in_ready;
  logic [ACTION_W-1:0]       action;
  logic [INDEX_W-1:0]        channel_index;
  logic signed [VALUE_W-1:0] channel_value;
  logic [CENTER_W-1:0]       channel_center;

  logic                  out_valid;
  logic                  out_ready;
  logic [INTERVAL_W-1:0] interval_counts;
  logic [KIND_W-1:0]     segment_kind;
  logic [INDEX_W-1:0]    pulse_channel;
  logic                  idle_level;

  // Set for the final stretch: no idling on either side.
  bit calm = 1'b0;

  int unsigned cycles = 0;

  interval_scoreboard sb = new();

  ppm_frame_interval_generator_top u_dut (.*);

  always #4 clk = ~clk;

  // Run limit. A hang on any handshake lands here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached, %0d segments still expected", $time, sb.pending());
      $display("FAIL ppm_frame_interval_generator_top");
      $finish;
    end
  end

  // Monitor. Check the result beat first so a same-edge input beat cannot jump the queue.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_segment(interval_counts, segment_kind, pulse_channel, idle_level);
      if (in_valid && in_ready)
        sb.take_beat(action, channel_index, channel_value, channel_center);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Receiver backpressure: random stall bursts between ready stretches.
  initial begin
    int n;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 15);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(negedge clk);
    end
  end

  // One input beat. Valid stays high on return; an idle burst drops it.
  task automatic send_beat(logic act, logic [3:0] idx, logic [15:0] val, logic [11:0] ctr);
    action         <= act;
    channel_index  <= idx;
    channel_value  <= val;
    channel_center <= ctr;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Tick beat: the table fields are don't-care, so keep them moving.
  task automatic send_tick();
    send_beat(ACT_TICK, 4'($urandom), 16'($urandom), 12'($urandom));
  endtask

  // Drain: wait out every expected segment.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Config beat; valid is left high so back-to-back writes need no toggle.
  task automatic write_register(logic [2:0] idx, logic [6:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [6:0] pol, logic [6:0] ext, logic [6:0] sync_step,
                                logic [6:0] frame_step, logic [6:0] count_step);
    write_register(REG_POLARITY, pol);
    write_register(REG_EXTENDED, ext);
    write_register(REG_SYNC_STEP, sync_step);
    write_register(REG_FRAME_STEP, frame_step);
    write_register(REG_COUNT_STEP, count_step);
    // unmapped index, must change nothing
    write_register(3'($urandom_range(int'(REG_COUNT_STEP) + 1, (1 << CFG_IDX_W) - 1)),
                   7'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-range noise, values around the clamp limits and small offsets.
  function automatic logic [15:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 2800)) - 1400);
      2: begin
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'(-1281);
          3:       return 16'(1281);
          4:       return 16'(-1024);
          default: return 16'(1024);
        endcase
      end
      default: return 16'(int'($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  // Mostly realistic centers so gaps land between the floor and the ceiling.
  function automatic logic [11:0] pick_center();
    if ($urandom_range(0, 9) < 7) return 12'($urandom_range(800, 2200));
    return 12'($urandom);
  endfunction

  // Ticks dominate so frames run through; table writes land anywhere in a frame.
  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3)
        send_beat(ACT_WRITE, 4'($urandom), pick_value(), pick_center());
      else
        send_tick();
    end
  endtask

  initial begin
    logic [6:0] pol_set[4];
    logic [6:0] ext_set[4];
    logic [6:0] sync_set[4];
    logic [6:0] frame_set[4];
    logic [6:0] count_set[4];

    // max, min, then raw codes past both ends of each range (saturated inside)
    pol_set   = '{7'd1, 7'd0, 7'h7F, 7'h7E};
    ext_set   = '{7'd1, 7'd0, 7'h7E, 7'h7F};
    sync_set  = '{7'(10), 7'(-4), 7'(15), 7'(-16)};
    frame_set = '{7'(35), 7'(-20), 7'(63), 7'(-64)};
    count_set = '{7'(4), 7'(-2), 7'(7), 7'(-8)};

    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_TICK;
    channel_index  = '0;
    channel_value  = '0;
    channel_center = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_POLARITY;
    cfg_data       = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed frame at reset settings (8 channels, 600-count sync, clamp 1024).
    // Channel 0 drives its pulse below zero; channel 1 clips high at the widest center.
    send_beat(ACT_WRITE, 4'd0, 16'h8000, 12'd0);
    send_beat(ACT_WRITE, 4'd1, 16'h7FFF, 12'hFFF);
    send_beat(ACT_WRITE, 4'd2, 16'(1025), 12'd1500);
    send_beat(ACT_WRITE, 4'd3, 16'(-1025), 12'd1500);
    send_beat(ACT_WRITE, 4'd7, 16'd0, 12'd2000);
    send_beat(ACT_WRITE, 4'd15, 16'hFFFF, 12'hFFF);
    // setup, eight sync/channel pairs, closing sync and the gap
    repeat (19) send_tick();
    quiesce();

    // Register settings: extremes first, then random raw codes. Each phase ends at
    // a random point in a frame, so count changes also hit mid frame.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      calm = (p == NUM_SETTINGS - 1);
      if (p < 4)
        apply_settings(pol_set[p], ext_set[p], sync_set[p], frame_set[p], count_set[p]);
      else
        apply_settings(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                       7'($urandom));
      random_items(ITEMS_PER_SETTING);
      quiesce();
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d ticks, %0d table writes and %0d register writes over %0d settings.",
             sb.ticks, sb.table_writes, sb.reg_writes, NUM_SETTINGS + 1);
    $display("Segments checked: setup %0d, sync %0d, channel %0d, gap %0d; %0d mismatches.",
             sb.by_kind[SEG_SETUP], sb.by_kind[SEG_SYNC], sb.by_kind[SEG_CHANNEL],
             sb.by_kind[SEG_GAP], sb.fails);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("PASS ppm_frame_interval_generator_top");
    end else begin
      $display("FAIL ppm_frame_interval_generator_top");
    end
    $finish;
  end

endmodule
